// ===== rtl/spq_pkg.sv =====
// ============================================================================
// spq_pkg
// Shared types, register map and constants of the staff pitch quantizer.
// ============================================================================
`default_nettype none

package spq_pkg;

    // Number of half-step line positions around one staff
    localparam int LINE_COUNT = 33;
    // Half-step lines above the staff (and below it)
    localparam int LINES_OUTSIDE = 12;
    // Index of the bottom staff line
    localparam int LAST_STAFF_IDX = 20;

    // Exact position width in 1/32 pixel, and rounded position width
    localparam int X_W   = 20;
    localparam int POS_W = 14;

    localparam int STAFF_W = 16;
    localparam int GAP_W   = 12;
    localparam int PITCH_W = 7;

    // Register map (index = paddr[4:2])
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_LINE_ONE   = 3'd0;
    localparam t_reg_idx REG_LINE_TWO   = 3'd1;
    localparam t_reg_idx REG_LINE_THREE = 3'd2;
    localparam t_reg_idx REG_LINE_FOUR  = 3'd3;
    localparam t_reg_idx REG_LINE_FIVE  = 3'd4;
    localparam t_reg_idx REG_THICKNESS  = 3'd5;
    localparam t_reg_idx REG_SPACING    = 3'd6;

    localparam logic [GAP_W-1:0] THICKNESS_RST = 12'd16;
    localparam logic [GAP_W-1:0] SPACING_RST   = 12'd160;

    typedef logic [PITCH_W-1:0] t_pitch;
    typedef logic signed [POS_W-1:0] t_pos;

    localparam t_pitch PITCH_LOW  = 7'd43;
    localparam t_pitch PITCH_HIGH = 7'd98;

    // MIDI pitch of each line, top line first
    localparam t_pitch PITCH_OF_LINE [LINE_COUNT] = '{
        7'd98, 7'd96, 7'd95, 7'd93, 7'd91, 7'd89, 7'd88, 7'd86, 7'd84, 7'd83, 7'd81,
        7'd79, 7'd77, 7'd76, 7'd74, 7'd72, 7'd71, 7'd69, 7'd67, 7'd65, 7'd64, 7'd62,
        7'd60, 7'd59, 7'd57, 7'd55, 7'd53, 7'd52, 7'd50, 7'd48, 7'd47, 7'd45, 7'd43
    };

    // Divide a 1/32 pixel value by 32, rounding halves away from zero
    function automatic t_pos round32(input logic signed [X_W-1:0] x);
        logic [X_W-1:0] mag;
        logic [X_W-1:0] q;
        begin
            mag = x[X_W-1] ? X_W'(-x) : X_W'(x);
            q   = (mag + X_W'(16)) >> 5;
            round32 = x[X_W-1] ? -POS_W'(q) : POS_W'(q);
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/staff_pitch_quantizer.sv =====
// ============================================================================
// staff_pitch_quantizer
// Maps a note's vertical center row to the MIDI pitch of the nearest staff
// half-step line; notes that already carry a pitch pass through.
// ============================================================================
// An accepted item is registered in stages A, B, C and D before its result is on m_axis.
// Throughput: one item per cycle while m_axis does not stall; four register stages with a valid bit each.
// Line positions are rebuilt from the configuration registers every cycle
// into their own register bank, so they follow a write in the cycle after the register takes it.
// Reset (synchronous, i_rst_n low): empty pipeline, staff lines at 0,
// thickness 1.0 and spacing 10.0 pixels.
`default_nettype none

module staff_pitch_quantizer #(
    parameter int ROW_BITS = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,

    // Input item stream
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // [ROW_BITS-1:0] center_row, [ROW_BITS+6:ROW_BITS] current_pitch, zero pad
    input  wire  [((ROW_BITS + spq_pkg::PITCH_W + 7) / 8) * 8 - 1:0] s_axis_tdata,

    // Result item stream
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // [6:0] pitch, [7] zero pad
    output logic [7:0]           m_axis_tdata,
    // [0] assigned
    output logic                 m_axis_tuser,

    // Register port
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [4:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    import spq_pkg::*;

    // Distance width: signed difference of a position and a center row
    localparam int DIFF_W = ((POS_W > ROW_BITS + 1) ? POS_W : ROW_BITS + 1) + 1;
    localparam int DIST_W = DIFF_W - 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [STAFF_W-1:0] r_staff [5];
    logic [GAP_W-1:0]   r_thick;
    logic [GAP_W-1:0]   r_space;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_staff[k] <= '0;
            end
            r_thick <= THICKNESS_RST;
            r_space <= SPACING_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LINE_ONE:   r_staff[0] <= pwdata[STAFF_W-1:0];
                REG_LINE_TWO:   r_staff[1] <= pwdata[STAFF_W-1:0];
                REG_LINE_THREE: r_staff[2] <= pwdata[STAFF_W-1:0];
                REG_LINE_FOUR:  r_staff[3] <= pwdata[STAFF_W-1:0];
                REG_LINE_FIVE:  r_staff[4] <= pwdata[STAFF_W-1:0];
                REG_THICKNESS:  r_thick    <= pwdata[GAP_W-1:0];
                REG_SPACING:    r_space    <= pwdata[GAP_W-1:0];
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_LINE_ONE:   prdata = 32'(r_staff[0]);
            REG_LINE_TWO:   prdata = 32'(r_staff[1]);
            REG_LINE_THREE: prdata = 32'(r_staff[2]);
            REG_LINE_FOUR:  prdata = 32'(r_staff[3]);
            REG_LINE_FIVE:  prdata = 32'(r_staff[4]);
            REG_THICKNESS:  prdata = 32'(r_thick);
            REG_SPACING:    prdata = 32'(r_space);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Line position bank
    // Exact positions in 1/32 pixel, w = thickness + spacing:
    //   above the staff, index i:  2*s1 - (12 - i) * w
    //   staff lines / midpoints:   2*s(k) and s(k) + s(k+1)
    //   below the staff, index i:  2*s5 + (i - 20) * w
    // then round to whole rows. Negative rows can only appear as a prefix
    // of the lines above the staff, since those grow with the index.
    // ------------------------------------------------------------------
    t_pos r_pos   [LINE_COUNT];
    t_pos n_pos   [LINE_COUNT];

    always_comb begin
        logic signed [X_W-1:0] w_x;
        logic signed [X_W-1:0] two_top;
        logic signed [X_W-1:0] two_bot;
        logic signed [X_W-1:0] x;
        w_x     = $signed(X_W'(r_thick) + X_W'(r_space));
        two_top = $signed(X_W'(r_staff[0]) << 1);
        two_bot = $signed(X_W'(r_staff[4]) << 1);
        for (int i = 0; i < LINE_COUNT; i++) begin
            if (i < LINES_OUTSIDE) begin
                x = two_top - w_x * $signed(X_W'(LINES_OUTSIDE - i));
            end else if (i <= LAST_STAFF_IDX) begin
                if (((i - LINES_OUTSIDE) & 1) == 0) begin
                    x = $signed(X_W'(r_staff[(i - LINES_OUTSIDE) >> 1]) << 1);
                end else begin
                    x = $signed(X_W'(r_staff[(i - LINES_OUTSIDE) >> 1])
                              + X_W'(r_staff[((i - LINES_OUTSIDE) >> 1) + 1]));
                end
            end else begin
                x = two_bot + w_x * $signed(X_W'(i - LAST_STAFF_IDX));
            end
            n_pos[i] = round32(x);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its content
    // moves on in the same cycle.
    // ------------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic adv_a, adv_b, adv_c, adv_d;

    assign adv_d = !r_d_valid || m_axis_tready;
    assign adv_c = !r_c_valid || adv_d;
    assign adv_b = !r_b_valid || adv_c;
    assign adv_a = !r_a_valid || adv_b;

    assign s_axis_tready = adv_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (adv_a) r_a_valid <= s_axis_tvalid;
            if (adv_b) r_b_valid <= r_a_valid;
            if (adv_c) r_c_valid <= r_b_valid;
            if (adv_d) r_d_valid <= r_c_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: capture the item and decide pass-through
    // ------------------------------------------------------------------
    logic [ROW_BITS-1:0] r_a_center;
    t_pitch              r_a_pitch;
    logic                r_a_pass;
    logic [ROW_BITS-1:0] in_center;
    t_pitch              in_pitch;

    assign in_center = s_axis_tdata[ROW_BITS-1:0];
    assign in_pitch  = s_axis_tdata[ROW_BITS +: PITCH_W];

    always_ff @(posedge i_clk) begin
        if (adv_a && s_axis_tvalid) begin
            r_a_center <= in_center;
            r_a_pitch  <= in_pitch;
            r_a_pass   <= (in_pitch != '0) || (in_center == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage B: distance from the center to every line
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] r_b_dist [LINE_COUNT];
    logic [DIST_W-1:0] n_b_dist [LINE_COUNT];
    t_pitch            r_b_pitch;
    logic              r_b_pass;

    always_comb begin
        logic signed [DIFF_W-1:0] diff;
        logic        [DIFF_W-1:0] mag;
        for (int i = 0; i < LINE_COUNT; i++) begin
            diff = DIFF_W'(r_pos[i]) - DIFF_W'($signed({1'b0, r_a_center}));
            mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
            n_b_dist[i] = mag[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_b && r_a_valid) begin
            r_b_dist  <= n_b_dist;
            r_b_pitch <= r_a_pitch;
            r_b_pass  <= r_a_pass;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: the scan stops at the first line farther away than the
    // line before it; flag each line that would end the scan that way.
    // Negative lines are skipped, and they only form a prefix, so the line
    // before a stop candidate must itself be non-negative.
    // ------------------------------------------------------------------
    logic [LINE_COUNT-2:0] r_c_stop;
    logic [LINE_COUNT-2:0] n_c_stop;
    t_pitch                r_c_pitch;
    logic                  r_c_pass;

    always_comb begin
        for (int k = 0; k < LINE_COUNT - 1; k++) begin
            n_c_stop[k] = !r_pos[k][POS_W-1] && (r_b_dist[k + 1] > r_b_dist[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_c && r_b_valid) begin
            r_c_stop  <= n_c_stop;
            r_c_pitch <= r_b_pitch;
            r_c_pass  <= r_b_pass;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: pick the first stop (else the last line), look up pitch or keep a pass-through pitch
    // ------------------------------------------------------------------
    t_pitch r_d_pitch;
    logic   r_d_assigned;
    t_pitch n_lookup;

    always_comb begin
        n_lookup = PITCH_OF_LINE[LINE_COUNT - 1];
        for (int k = LINE_COUNT - 2; k >= 0; k--) begin
            if (r_c_stop[k]) begin
                n_lookup = PITCH_OF_LINE[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_d && r_c_valid) begin
            r_d_pitch    <= r_c_pass ? r_c_pitch : n_lookup;
            r_d_assigned <= !r_c_pass;
        end
    end

    assign m_axis_tvalid = r_d_valid;
    assign m_axis_tdata  = {1'b0, r_d_pitch};
    assign m_axis_tuser  = r_d_assigned;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_lookup_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[PITCH_W-1:0] >= PITCH_LOW && m_axis_tdata[PITCH_W-1:0] <= PITCH_HIGH))
        else $error("looked-up pitch outside the line table");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_d_valid |-> s_axis_tready)
        else $error("input stalled while the output register is empty");

    a_pass_unassigned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && adv_d && r_c_pass) |=> (m_axis_tvalid && !m_axis_tuser))
        else $error("pass-through item marked as assigned");

    a_thick_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && cfg_idx == REG_THICKNESS) |=> (r_thick == $past(pwdata[GAP_W-1:0])))
        else $error("thickness register did not take the write");

endmodule

`default_nettype wire
